@@ design/ccx_pkg.sv @@
package ccx_pkg;

    // configuration port widths and register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_STATIC_KEY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 2'd1;

    // direction codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // one input byte with its framing
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic [7:0] random_key;
    } item_t;

    // one result byte with its flags
    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_end;
        logic       checksum_ok;
    } result_t;

    // programmed configuration
    typedef struct packed {
        logic [7:0] static_key;
        logic       direction;
    } cfg_t;

endpackage

@@ design/ccx_cfg_regs.sv @@
module ccx_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ccx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ccx_pkg::CFG_DATA_W-1:0] cfg_data,
    output ccx_pkg::cfg_t                  cfg
);

    ccx_pkg::cfg_t cfg_reg;
    ccx_pkg::cfg_t cfg_next;
    logic          wr;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    // register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (cfg_index)
                ccx_pkg::CFG_STATIC_KEY: cfg_next.static_key = cfg_data;
                ccx_pkg::CFG_DIRECTION:  cfg_next.direction  = cfg_data[0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.static_key <= 8'd0;
            cfg_reg.direction  <= ccx_pkg::DIR_ENCODE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/ccx_in_stage.sv @@
module ccx_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  ccx_pkg::item_t in_item,
    input  logic           step,
    output logic           item_valid,
    output ccx_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    ccx_pkg::item_t item_reg;
    logic           load;

    // hold off the sender only while a held request cannot move on
    assign in_stall   = valid_reg && !step;
    assign load       = in_valid && !in_stall;
    assign valid_next = load || (valid_reg && !step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ design/ccx_cipher.sv @@
module ccx_cipher (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  ccx_pkg::item_t   item,
    input  ccx_pkg::cfg_t    cfg,
    output ccx_pkg::result_t result
);

    logic [7:0] position_reg,     position_next;
    logic [7:0] plain_chain_reg,  plain_chain_next;
    logic [7:0] cipher_chain_reg, cipher_chain_next;
    logic [7:0] packet_key_reg,   packet_key_next;
    logic [7:0] running_sum_reg,  running_sum_next;
    logic [7:0] expected_sum_reg, expected_sum_next;

    logic [7:0] pc_base;
    logic [7:0] cc_base;
    logic [7:0] plain_pad;
    logic [7:0] cipher_pad;
    logic [7:0] t_byte;
    logic [7:0] res_byte;
    logic       ok;

    // packet start restarts position and chains and samples the key
    always_comb
    begin
        if (item.first_byte)
        begin
            position_next   = 8'd1;
            pc_base         = 8'd0;
            cc_base         = 8'd0;
            packet_key_next = item.random_key;
        end
        else
        begin
            position_next   = position_reg + 8'd1;
            pc_base         = plain_chain_reg;
            cc_base         = cipher_chain_reg;
            packet_key_next = packet_key_reg;
        end
    end

    // keystream pads of the two chain stages
    assign plain_pad  = pc_base + packet_key_next + position_next;
    assign cipher_pad = cc_base + cfg.static_key + position_next;

    // chain update and checksum tracking
    always_comb
    begin
        running_sum_next  = running_sum_reg;
        expected_sum_next = expected_sum_reg;
        ok                = 1'b0;
        t_byte            = 8'd0;
        if (cfg.direction == ccx_pkg::DIR_ENCODE)
        begin
            plain_chain_next  = item.data_byte ^ plain_pad;
            cipher_chain_next = plain_chain_next ^ cipher_pad;
            res_byte          = cipher_chain_next;
        end
        else
        begin
            t_byte            = item.data_byte ^ cipher_pad;
            cipher_chain_next = item.data_byte;
            res_byte          = t_byte ^ plain_pad;
            plain_chain_next  = t_byte;
            if (item.first_byte)
            begin
                expected_sum_next = res_byte;
                running_sum_next  = 8'd0;
            end
            else
            begin
                running_sum_next = running_sum_reg + res_byte;
            end
            ok = item.last_byte && (running_sum_next == expected_sum_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg     <= 8'd0;
            plain_chain_reg  <= 8'd0;
            cipher_chain_reg <= 8'd0;
            packet_key_reg   <= 8'd0;
            running_sum_reg  <= 8'd0;
            expected_sum_reg <= 8'd0;
        end
        else if (step)
        begin
            position_reg     <= position_next;
            plain_chain_reg  <= plain_chain_next;
            cipher_chain_reg <= cipher_chain_next;
            packet_key_reg   <= packet_key_next;
            running_sum_reg  <= running_sum_next;
            expected_sum_reg <= expected_sum_next;
        end
    end

    assign result.out_byte    = res_byte;
    assign result.packet_end  = item.last_byte;
    assign result.checksum_ok = ok;

    // packet start puts the position back to one
    a_first_pos: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.first_byte |=> position_reg == 8'd1)
        else $error("position not restarted on packet start");

    // position advances by one within a packet
    a_pos_inc: assert property (@(posedge clk) disable iff (!rst_n)
        step && !item.first_byte |=> position_reg == $past(position_reg) + 8'd1)
        else $error("position did not advance");

    // encoding leaves the checksum state alone
    a_enc_sum: assert property (@(posedge clk) disable iff (!rst_n)
        step && cfg.direction == ccx_pkg::DIR_ENCODE
        |=> running_sum_reg == $past(running_sum_reg)
            && expected_sum_reg == $past(expected_sum_reg))
        else $error("checksum state changed while encoding");

    // decoding chains on the received ciphertext
    a_dec_chain: assert property (@(posedge clk) disable iff (!rst_n)
        step && cfg.direction == ccx_pkg::DIR_DECODE
        |=> cipher_chain_reg == $past(item.data_byte))
        else $error("decode chain not taken from input byte");

endmodule

@@ design/ccx_out_stage.sv @@
module ccx_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  ccx_pkg::result_t result,
    output logic             step,
    output logic             out_valid,
    input  logic             out_stall,
    output ccx_pkg::result_t out_result
);

    logic             valid_reg;
    logic             valid_next;
    ccx_pkg::result_t result_reg;
    logic             free;

    // the result register takes a new request when empty or being drained
    assign free       = !valid_reg || !out_stall;
    assign step       = item_valid && free;
    assign valid_next = step || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

@@ design/chained_xor_packet_cipher_core.sv @@
// Chained XOR packet cipher, one byte of a packet's protected region per request.
// Input channel (in_valid / in_stall) carries data_byte with first_byte and
// last_byte framing; the checksum byte comes first, random_key is sampled on it.
// Output channel (out_valid / out_stall) returns out_byte, packet_end and
// checksum_ok: ciphertext when encoding, plaintext plus the checksum verdict on
// the last byte when decoding.
// Configuration port (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 is
// the static key, index 1 the direction (0 encode, 1 decode). cfg_ready is
// always high; write only while no request is in flight.
// out_valid rises once an accepted request has passed the input register, then
// the chain update and the result register. Throughput is one byte per cycle
// while the receiver does not stall, set by the 8-bit chain loop in the
// cipher stage.
// Reset clears position, chains, key and sums to zero and clears both valid
// flags, leaving both channels empty.
// When the receiver stalls the result holds; the input register still takes
// one more request, after which in_stall rises until the output drains.
module chained_xor_packet_cipher_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     data_byte,
    input  logic                           first_byte,
    input  logic                           last_byte,
    input  logic [7:0]                     random_key,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     out_byte,
    output logic                           packet_end,
    output logic                           checksum_ok,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ccx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ccx_pkg::CFG_DATA_W-1:0] cfg_data
);

    ccx_pkg::cfg_t    cfg;
    ccx_pkg::item_t   in_item;
    ccx_pkg::item_t   item;
    ccx_pkg::result_t result;
    ccx_pkg::result_t out_result;
    logic             item_valid;
    logic             step;

    // gather input fields
    assign in_item.data_byte  = data_byte;
    assign in_item.first_byte = first_byte;
    assign in_item.last_byte  = last_byte;
    assign in_item.random_key = random_key;

    ccx_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ccx_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .step       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    ccx_cipher u_cipher (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .cfg    (cfg),
        .result (result)
    );

    ccx_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .step       (step),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    // spread result fields
    assign out_byte    = out_result.out_byte;
    assign packet_end  = out_result.packet_end;
    assign checksum_ok = out_result.checksum_ok;

endmodule

@@ tb/cipher_checker.sv @@
`timescale 1ns / 100ps

module cipher_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [7:0]                     data_byte,
    input  logic                           first_byte,
    input  logic                           last_byte,
    input  logic [7:0]                     random_key,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [7:0]                     out_byte,
    input  logic                           packet_end,
    input  logic                           checksum_ok,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [ccx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ccx_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending
);

    // results still owed by the block, oldest first
    ccx_pkg::result_t owed_results[$];
    int               mismatches;

    // shadow configuration
    logic [7:0] key_static;
    logic       dir_mode;

    // shadow cipher state
    logic [7:0] pos_q;
    logic [7:0] plain_q;
    logic [7:0] cipher_q;
    logic [7:0] pkt_key;
    logic [7:0] sum_acc;
    logic [7:0] sum_ref;

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
        mismatches++;
    endtask

    // advance the cipher by one request byte and give its result
    function automatic ccx_pkg::result_t cipher_step(input ccx_pkg::item_t it);
        ccx_pkg::result_t r;
        logic [7:0]       t;
        r = '0;
        if (it.first_byte)
        begin
            pkt_key  = it.random_key;
            pos_q    = 8'd1;
            plain_q  = 8'd0;
            cipher_q = 8'd0;
        end
        else
        begin
            pos_q = pos_q + 8'd1;
        end
        if (dir_mode == ccx_pkg::DIR_ENCODE)
        begin
            plain_q    = it.data_byte ^ (plain_q + pkt_key + pos_q);
            cipher_q   = plain_q ^ (cipher_q + key_static + pos_q);
            r.out_byte = cipher_q;
        end
        else
        begin
            t          = it.data_byte ^ (cipher_q + key_static + pos_q);
            cipher_q   = it.data_byte;
            r.out_byte = t ^ (plain_q + pkt_key + pos_q);
            plain_q    = t;
            // first decoded byte is the checksum, the rest are summed
            if (it.first_byte)
            begin
                sum_ref = r.out_byte;
                sum_acc = 8'd0;
            end
            else
            begin
                sum_acc = sum_acc + r.out_byte;
            end
            if (it.last_byte)
                r.checksum_ok = (sum_acc == sum_ref);
        end
        r.packet_end = it.last_byte;
        return r;
    endfunction

    // watch config writes, requests in and results out
    always @(posedge clk or negedge rst_n)
    begin
        ccx_pkg::item_t   seen;
        ccx_pkg::result_t want;
        if (!rst_n)
        begin
            key_static = 8'd0;
            dir_mode   = ccx_pkg::DIR_ENCODE;
            pos_q      = 8'd0;
            plain_q    = 8'd0;
            cipher_q   = 8'd0;
            pkt_key    = 8'd0;
            sum_acc    = 8'd0;
            sum_ref    = 8'd0;
            mismatches = 0;
            owed_results.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ccx_pkg::CFG_STATIC_KEY: key_static = cfg_data;
                    ccx_pkg::CFG_DIRECTION:  dir_mode   = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                seen.data_byte  = data_byte;
                seen.first_byte = first_byte;
                seen.last_byte  = last_byte;
                seen.random_key = random_key;
                owed_results.push_back(cipher_step(seen));
            end
            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    report_mismatch("unexpected result out_byte", 8'h00, out_byte);
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (out_byte !== want.out_byte)
                        report_mismatch("out_byte", want.out_byte, out_byte);
                    if (packet_end !== want.packet_end)
                        report_mismatch("packet_end", 8'(want.packet_end), 8'(packet_end));
                    if (checksum_ok !== want.checksum_ok)
                        report_mismatch("checksum_ok", 8'(want.checksum_ok), 8'(checksum_ok));
                end
            end
            fail_count <= mismatches;
            pending    <= owed_results.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int HOLD_LEN   = 300;
    localparam int QUIET_MAX  = 3000;
    localparam int DRAIN_PAD  = 8;
    localparam int PHASE_ITEMS = 130;

    logic                           clk        = 1'b0;
    logic                           rst_n      = 1'b0;
    logic                           in_valid   = 1'b0;
    logic [7:0]                     data_byte  = 8'd0;
    logic                           first_byte = 1'b0;
    logic                           last_byte  = 1'b0;
    logic [7:0]                     random_key = 8'd0;
    logic                           out_stall  = 1'b0;
    logic                           cfg_valid  = 1'b0;
    logic [ccx_pkg::CFG_IDX_W-1:0]  cfg_index  = ccx_pkg::CFG_STATIC_KEY;
    logic [ccx_pkg::CFG_DATA_W-1:0] cfg_data   = '0;
    int                             hold_count = 0;

    logic                           in_stall;
    logic                           out_valid;
    logic [7:0]                     out_byte;
    logic                           packet_end;
    logic                           checksum_ok;
    logic                           cfg_ready;
    int                             fail_count;
    int                             pending;

    // stimulus knobs
    int                             tx_pct     = 0;
    int                             rx_pct     = 0;
    int                             items_sent = 0;
    logic [7:0]                     cur_sk     = 8'd0;
    logic                           cur_dir    = ccx_pkg::DIR_ENCODE;

    chained_xor_packet_cipher_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .first_byte  (first_byte),
        .last_byte   (last_byte),
        .random_key  (random_key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .packet_end  (packet_end),
        .checksum_ok (checksum_ok),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    cipher_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .first_byte  (first_byte),
        .last_byte   (last_byte),
        .random_key  (random_key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .packet_end  (packet_end),
        .checksum_ok (checksum_ok),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, or one long hold-off on request
    initial
    begin
        int holds_done;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_count)
            begin
                holds_done = hold_count;
                out_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < rx_pct);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_MAX)
            begin
                $display("FAIL chained_xor_packet_cipher_core");
                $finish;
            end
        end
    end

    // offer one request byte and wait until it is taken
    task automatic send_byte(input logic [7:0] d, input logic f, input logic l,
                             input logic [7:0] k);
        while ($urandom_range(0, 99) < tx_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= d;
        first_byte <= f;
        last_byte  <= l;
        random_key <= k;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // stop offering and wait until every result is out
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ccx_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ccx_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic set_config(input logic [7:0] sk, input logic dir);
        wait_idle();
        write_reg(ccx_pkg::CFG_STATIC_KEY, sk);
        write_reg(ccx_pkg::CFG_DIRECTION, ccx_pkg::CFG_DATA_W'(dir));
        cfg_valid <= 1'b0;
        cur_sk  = sk;
        cur_dir = dir;
    endtask

    // turn plaintext into the ciphertext a decoder turns back into it
    function automatic void seal_bytes(ref logic [7:0] b[$], input logic [7:0] k,
                                       input logic [7:0] s);
        logic [7:0] p;
        logic [7:0] c;
        logic [7:0] pos;
        p = 8'd0;
        c = 8'd0;
        foreach (b[j])
        begin
            pos  = 8'(j + 1);
            p    = b[j] ^ (p + k + pos);
            c    = p ^ (c + s + pos);
            b[j] = c;
        end
    endfunction

    // one framed packet: checksum byte then payload, optionally flip direction midway
    task automatic send_packet(input int len, input bit good_sum, input int split_at);
        logic [7:0] bytes[$];
        logic [7:0] sum;
        logic [7:0] key;
        sum = 8'd0;
        key = 8'($urandom_range(0, 255));
        bytes.push_back(8'd0);
        for (int j = 1; j < len; j++)
        begin
            bytes.push_back(8'($urandom_range(0, 255)));
            sum += bytes[j];
        end
        bytes[0] = good_sum ? sum : 8'($urandom_range(0, 255));
        if (cur_dir == ccx_pkg::DIR_DECODE)
            seal_bytes(bytes, key, cur_sk);
        for (int j = 0; j < len; j++)
        begin
            if (split_at > 0 && j == split_at)
                set_config(cur_sk, ~cur_dir);
            send_byte(bytes[j], j == 0, j == len - 1,
                      (j == 0) ? key : 8'($urandom_range(0, 255)));
        end
    endtask

    // main sequence
    initial
    begin
        int         r;
        int         target;
        logic [7:0] sk;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: bytes before any packet start, then extremes in encode
        set_config(8'h00, ccx_pkg::DIR_ENCODE);
        send_byte(8'h00, 1'b0, 1'b0, 8'hFF);
        send_byte(8'hFF, 1'b0, 1'b1, 8'h00);
        send_byte(8'hFF, 1'b1, 1'b0, 8'hFF);
        send_byte(8'h00, 1'b0, 1'b0, 8'h00);
        send_byte(8'hFF, 1'b0, 1'b1, 8'hFF);
        // one-byte packet, then a byte after a last byte with no new start
        send_byte(8'h00, 1'b1, 1'b1, 8'h00);
        send_byte(8'h5A, 1'b0, 1'b0, 8'hA5);

        // directed decode: good packet, one-byte packets, broken checksum
        set_config(8'hFF, ccx_pkg::DIR_DECODE);
        send_packet(4, 1'b1, 0);
        send_packet(1, 1'b1, 0);
        send_byte(8'hFF, 1'b1, 1'b1, 8'hFF);
        send_packet(3, 1'b0, 0);
        // direction flips in mid-packet, both ways
        send_packet(5, 1'b1, 2);
        send_packet(4, 1'b1, 2);
        set_config(8'h3C, ccx_pkg::DIR_DECODE);

        // random phases over several settings and idling patterns
        for (int ph = 0; ph < 10; ph++)
        begin
            sk = (ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : 8'($urandom_range(0, 255));
            set_config(sk, ph[0] ? ccx_pkg::DIR_ENCODE : ccx_pkg::DIR_DECODE);
            case (ph % 5)
                0: begin tx_pct = 0;  rx_pct = 0;  end
                1: begin tx_pct = 78; rx_pct = 0;  end
                2: begin tx_pct = 0;  rx_pct = 78; end
                3: begin tx_pct = 7;  rx_pct = 7;  end
                default:
                begin
                    tx_pct = 0;
                    rx_pct = 0;
                    hold_count <= hold_count + 1;
                end
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    send_packet($urandom_range(200, 300), 1'b1, 0);
                else if (r < 72)
                    send_packet($urandom_range(1, 12), 1'b1, 0);
                else if (r < 86)
                    send_packet($urandom_range(1, 12), 1'b0, 0);
                else
                    repeat ($urandom_range(1, 4))
                        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
        end

        tx_pct = 0;
        rx_pct = 0;
        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("PASS chained_xor_packet_cipher_core");
        else
            $display("FAIL chained_xor_packet_cipher_core");
        $finish;
    end

endmodule

@@ files.f @@
design/ccx_pkg.sv
design/ccx_cfg_regs.sv
design/ccx_in_stage.sv
design/ccx_cipher.sv
design/ccx_out_stage.sv
design/chained_xor_packet_cipher_core.sv
tb/cipher_checker.sv
tb/testbench.sv
